[design/csv_pkg.sv]
// Shared constants, types and sequencer states for the cell voltage statistics block.
package csv_pkg;

    localparam int MAX_CELLS = 16;

    localparam int CELL_W   = 17;
    localparam int MV_W     = 18;
    localparam int POS_W    = 5;
    localparam int SPREAD_W = 19;
    localparam int MEAN_W   = 17;

    // frame counter holds 0..MAX_CELLS
    localparam int CNT_W    = $clog2(MAX_CELLS + 1);
    localparam int SUM_W    = CELL_W + $clog2(MAX_CELLS);
    localparam int ALU_W    = (SUM_W + 1 > SPREAD_W) ? SUM_W + 1 : SPREAD_W;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    localparam logic signed [MV_W-1:0] MIN_SENTINEL = MV_W'(100000);
    localparam logic signed [MV_W-1:0] MAX_SENTINEL = -MV_W'(100000);

    localparam int IN_TDATA_W = ((CELL_W + 7) / 8) * 8;

    // result field offsets inside m_tdata, lowest first
    localparam int OFS_MIN_MV  = 0;
    localparam int OFS_MIN_POS = OFS_MIN_MV + MV_W;
    localparam int OFS_MAX_MV  = OFS_MIN_POS + POS_W;
    localparam int OFS_MAX_POS = OFS_MAX_MV + MV_W;
    localparam int OFS_SPREAD  = OFS_MAX_POS + POS_W;
    localparam int OFS_MEAN    = OFS_SPREAD + SPREAD_W;
    localparam int OFS_USED    = OFS_MEAN + MEAN_W;
    localparam int OUT_BITS    = OFS_USED + POS_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // first member lands in the highest bits
    typedef struct packed {
        logic [POS_W-1:0]           used_cells;
        logic signed [MEAN_W-1:0]   mean_mv;
        logic signed [SPREAD_W-1:0] spread_mv;
        logic [POS_W-1:0]           max_pos;
        logic signed [MV_W-1:0]     max_mv;
        logic [POS_W-1:0]           min_pos;
        logic signed [MV_W-1:0]     min_mv;
    } csv_result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIN,
        ST_MAX,
        ST_ACC,
        ST_SPREAD,
        ST_ABS,
        ST_DIV,
        ST_NEG,
        ST_OUT
    } csv_state_t;

endpackage

[design/csv_alu.sv]
// Shared add/subtract unit used for every compare, sum and division step.
module csv_alu
    import csv_pkg::*;
(
    input  logic signed [ALU_W-1:0] a,
    input  logic signed [ALU_W-1:0] b,
    input  logic                    sub,
    output logic signed [ALU_W-1:0] y
);

    assign y = sub ? (a - b) : (a + b);

endmodule

[design/csv_core.sv]
// Sequencer and frame registers: min/max/sum per item, spread and mean at frame end.
module csv_core
    import csv_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [CELL_W-1:0] in_cell,
    input  logic                     in_last,
    output logic                     res_valid,
    input  logic                     res_ready,
    output csv_result_t              res
);

    csv_state_t state_reg, state_next;

    logic signed [CELL_W-1:0]   cell_reg;
    logic                       last_reg;
    logic signed [MV_W-1:0]     low_reg;
    logic signed [MV_W-1:0]     high_reg;
    logic [CNT_W-1:0]           low_pos_reg;
    logic [CNT_W-1:0]           high_pos_reg;
    logic signed [SUM_W-1:0]    total_reg;
    logic [CNT_W-1:0]           seen_reg;
    logic signed [SPREAD_W-1:0] spread_reg;
    logic [SUM_W-1:0]           dq_reg;
    logic [CNT_W-1:0]           rem_reg;
    logic [DIV_CNT_W-1:0]       div_cnt_reg;
    logic                       neg_reg;

    logic signed [ALU_W-1:0] alu_a, alu_b, alu_y;
    logic                    alu_sub;

    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] divisor;
    logic [CNT_W:0]   partial;
    logic             cell_positive;
    logic             room;
    logic             div_done;

    assign pos           = CNT_W'(seen_reg + 1'b1);
    assign divisor       = (seen_reg == '0) ? CNT_W'(1) : seen_reg;
    assign partial       = {rem_reg, dq_reg[SUM_W-1]};
    assign cell_positive = !cell_reg[CELL_W-1] && (cell_reg != '0);
    assign room          = (seen_reg < CNT_W'(MAX_CELLS));
    assign div_done      = (div_cnt_reg == DIV_CNT_W'(SUM_W - 1));

    csv_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .y   (alu_y)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (room) begin
                        state_next = ST_MIN;
                    end else if (in_last) begin
                        state_next = ST_SPREAD;
                    end
                end
            end
            ST_MIN:    state_next = ST_MAX;
            ST_MAX:    state_next = ST_ACC;
            ST_ACC:    state_next = last_reg ? ST_SPREAD : ST_IDLE;
            ST_SPREAD: state_next = ST_ABS;
            ST_ABS:    state_next = ST_DIV;
            ST_DIV:    state_next = div_done ? ST_NEG : ST_DIV;
            ST_NEG:    state_next = ST_OUT;
            ST_OUT:    state_next = res_ready ? ST_IDLE : ST_OUT;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        alu_a     = '0;
        alu_b     = '0;
        alu_sub   = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_MIN: begin
                alu_a   = ALU_W'(cell_reg);
                alu_b   = ALU_W'(low_reg);
                alu_sub = 1'b1;
            end
            ST_MAX: begin
                alu_a   = ALU_W'(cell_reg);
                alu_b   = ALU_W'(high_reg);
                alu_sub = 1'b1;
            end
            ST_ACC: begin
                alu_a = ALU_W'(total_reg);
                alu_b = ALU_W'(cell_reg);
            end
            ST_SPREAD: begin
                alu_a   = ALU_W'(high_reg);
                alu_b   = ALU_W'(low_reg);
                alu_sub = 1'b1;
            end
            ST_ABS: begin
                // magnitude of the sum for the unsigned divide
                if (neg_reg) begin
                    alu_b   = ALU_W'(total_reg);
                    alu_sub = 1'b1;
                end else begin
                    alu_a = ALU_W'(total_reg);
                end
            end
            ST_DIV: begin
                alu_a   = ALU_W'(partial);
                alu_b   = ALU_W'(divisor);
                alu_sub = 1'b1;
            end
            ST_NEG: begin
                if (neg_reg) begin
                    alu_b   = ALU_W'(dq_reg);
                    alu_sub = 1'b1;
                end else begin
                    alu_a = ALU_W'(dq_reg);
                end
            end
            ST_OUT:  res_valid = 1'b1;
            default: in_ready = 1'b0;
        endcase
    end

    assign res.min_mv     = low_reg;
    assign res.min_pos    = POS_W'(low_pos_reg);
    assign res.max_mv     = high_reg;
    assign res.max_pos    = POS_W'(high_pos_reg);
    assign res.spread_mv  = spread_reg;
    assign res.mean_mv    = dq_reg[MEAN_W-1:0];
    assign res.used_cells = POS_W'(seen_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // item payload and divider working registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cell_reg <= in_cell;
                    last_reg <= in_last;
                end
            end
            ST_SPREAD: begin
                spread_reg <= alu_y[SPREAD_W-1:0];
                neg_reg    <= total_reg[SUM_W-1];
            end
            ST_ABS: begin
                dq_reg      <= alu_y[SUM_W-1:0];
                rem_reg     <= '0;
                div_cnt_reg <= '0;
            end
            ST_DIV: begin
                // restoring step: keep the trial remainder when it did not go negative
                if (!alu_y[ALU_W-1]) begin
                    rem_reg <= alu_y[CNT_W-1:0];
                end else begin
                    rem_reg <= partial[CNT_W-1:0];
                end
                dq_reg      <= {dq_reg[SUM_W-2:0], !alu_y[ALU_W-1]};
                div_cnt_reg <= DIV_CNT_W'(div_cnt_reg + 1'b1);
            end
            ST_NEG:  dq_reg <= alu_y[SUM_W-1:0];
            default: ;
        endcase
    end

    // frame statistics
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg      <= MIN_SENTINEL;
            high_reg     <= MAX_SENTINEL;
            low_pos_reg  <= '0;
            high_pos_reg <= '0;
            total_reg    <= '0;
            seen_reg     <= '0;
        end else begin
            case (state_reg)
                ST_MIN: begin
                    if (cell_positive && alu_y[ALU_W-1]) begin
                        low_reg     <= MV_W'(cell_reg);
                        low_pos_reg <= pos;
                    end
                end
                ST_MAX: begin
                    // strictly greater keeps the first of equal values
                    if (!alu_y[ALU_W-1] && (alu_y != '0)) begin
                        high_reg     <= MV_W'(cell_reg);
                        high_pos_reg <= pos;
                    end
                end
                ST_ACC: begin
                    total_reg <= alu_y[SUM_W-1:0];
                    seen_reg  <= pos;
                end
                ST_OUT: begin
                    if (res_ready) begin
                        low_reg      <= MIN_SENTINEL;
                        high_reg     <= MAX_SENTINEL;
                        low_pos_reg  <= '0;
                        high_pos_reg <= '0;
                        total_reg    <= '0;
                        seen_reg     <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

[design/cell_voltage_statistics.sv]
// Cell voltage statistics: one result item per pack frame of cell voltages.
//
// Input channel s_*: one cell voltage per item, s_tlast closes the pack frame.
// Only the first MAX_CELLS cells of a frame are counted; later cells are
// dropped, but their tlast still closes the frame.
// Result channel m_*: one item per frame with min, max, their positions,
// spread, truncated mean and cell count.
// Every counted cell runs through one shared add/subtract unit for a min
// compare, a max compare and a sum, and s_tready stays low until the sum is
// done, so the next cell waits; a dropped cell is taken without these steps.
// At frame end the same unit forms the spread, the magnitude of the sum, a
// restoring divide of SUM_W steps (21 at 16 cells) and the sign fix: the
// result then waits in ST_OUT until the output register is free, and
// m_tvalid rises as the result is loaded into that register.
// The output register lets the next frame start while a result waits. If the
// receiver still holds the previous result when the next one is done, the
// sequencer waits and s_tready stays low until the register frees.
// Reset (aresetn low, synchronous) empties the output register and clears
// the frame statistics to their sentinels.
module cell_voltage_statistics
    import csv_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // cell_mv[16:0], zero fill
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // min_mv, min_pos, max_mv, max_pos, spread_mv, mean_mv, used_cells, zero fill
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic        res_valid, res_ready, res_take;
    csv_result_t res;

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    csv_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cell   (s_tdata[CELL_W-1:0]),
        .in_last   (s_tlast),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_tvalid_reg || m_tready;
    assign res_take  = res_valid && res_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_take) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_tdata_reg <= OUT_TDATA_W'(res);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[design/csv_checker.sv]
// Port-level checks for the cell voltage statistics block, bound to the top level.
module csv_checker
    import csv_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic signed [MV_W-1:0]     min_mv;
    logic signed [MV_W-1:0]     max_mv;
    logic [POS_W-1:0]           min_pos;
    logic signed [SPREAD_W-1:0] spread_mv;

    assign min_mv    = m_tdata[OFS_MIN_MV +: MV_W];
    assign max_mv    = m_tdata[OFS_MAX_MV +: MV_W];
    assign min_pos   = m_tdata[OFS_MIN_POS +: POS_W];
    assign spread_mv = m_tdata[OFS_SPREAD +: SPREAD_W];

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item dropped or changed while stalled");

    // a result is only loaded out of the busy sequencer
    a_result_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result item appeared while input side was idle");

    a_spread: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> spread_mv == (SPREAD_W'(max_mv) - SPREAD_W'(min_mv)))
        else $error("spread does not match max minus min");

    // the sentinel and a zero position go together
    a_min_sentinel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (MAX_CELLS < 32) |-> (min_pos == '0) == (min_mv == MIN_SENTINEL))
        else $error("min position and min sentinel disagree");

endmodule

bind cell_voltage_statistics csv_checker u_csv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/cell_voltage_statistics_tb.sv]
// Self-checking testbench for cell_voltage_statistics: random pack frames, per-frame stats check.
module cell_voltage_statistics_tb;
    import csv_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int STALL_LIMIT = 4000;   // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = 60;    // idle cycles after the last result before the run ends
    localparam int RANDOM_CELLS = 500;

    typedef struct {
        logic signed [CELL_W-1:0] mv;
        bit                       last;
    } cell_item_t;

    typedef struct {
        logic signed [MV_W-1:0]     min_mv;
        logic [POS_W-1:0]           min_pos;
        logic signed [MV_W-1:0]     max_mv;
        logic [POS_W-1:0]           max_pos;
        logic signed [SPREAD_W-1:0] spread_mv;
        logic signed [MEAN_W-1:0]   mean_mv;
        logic [POS_W-1:0]           used_cells;
    } frame_stats_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    cell_voltage_statistics dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    cell_item_t   pending_cells[$];
    frame_stats_t expected_frames[$];
    int           total_cells = 0;
    int           cells_sent = 0;
    int           mismatches = 0;
    int           quiet_cycles = 0;

    // frame accumulator, mirrors the block's state
    int           low_mv;
    int           high_mv;
    int           low_at;
    int           high_at;
    longint       cell_sum;
    int           cells_counted;

    function automatic void clear_frame_stats();
        low_mv = 100000;
        high_mv = -100000;
        low_at = 0;
        high_at = 0;
        cell_sum = 0;
        cells_counted = 0;
    endfunction

    // Folds one cell into the frame; returns 1 with the stats when the frame closes.
    function automatic bit fold_cell(input logic signed [CELL_W-1:0] mv, input bit last,
                                     output frame_stats_t stats);
        int     v;
        longint mean;
        v = mv;
        if (cells_counted < MAX_CELLS) begin
            cell_sum += v;
            if (v > 0 && v < low_mv) begin
                low_mv = v;
                low_at = cells_counted + 1;
            end
            if (v > high_mv) begin
                high_mv = v;
                high_at = cells_counted + 1;
            end
            cells_counted++;
        end
        if (!last)
            return 1'b0;
        mean = cell_sum / longint'(cells_counted == 0 ? 1 : cells_counted);
        stats.min_mv     = MV_W'(low_mv);
        stats.min_pos    = POS_W'(low_at);
        stats.max_mv     = MV_W'(high_mv);
        stats.max_pos    = POS_W'(high_at);
        stats.spread_mv  = SPREAD_W'(high_mv - low_mv);
        stats.mean_mv    = MEAN_W'(mean);
        stats.used_cells = POS_W'(cells_counted);
        clear_frame_stats();
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    function automatic bit gaps_allowed();
        // long stretch in the middle of the run with both sides streaming flat out
        return !(cells_sent >= 200 && cells_sent < 320);
    endfunction

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_cells.size() != 0 &&
                    (!gaps_allowed() || $urandom_range(0, 99) >= 8)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= IN_TDATA_W'($unsigned(pending_cells[0].mv));
                s_tlast  <= pending_cells[0].last;
                pending_cells.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver backpressure
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= !gaps_allowed() || $urandom_range(0, 99) >= 8;
    end

    // monitor, scoreboard and watchdog
    always @(posedge aclk) begin
        frame_stats_t stats;
        frame_stats_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                cells_sent++;
                if (fold_cell(s_tdata[CELL_W-1:0], s_tlast, stats))
                    expected_frames.push_back(stats);
            end
            if (m_tvalid && m_tready) begin
                if (expected_frames.size() == 0) begin
                    $display("%0t: unexpected result item, expected none, actual %h",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    want = expected_frames.pop_front();
                    check_field("min_mv", want.min_mv, $signed(m_tdata[OFS_MIN_MV +: MV_W]));
                    check_field("min_pos", want.min_pos, m_tdata[OFS_MIN_POS +: POS_W]);
                    check_field("max_mv", want.max_mv, $signed(m_tdata[OFS_MAX_MV +: MV_W]));
                    check_field("max_pos", want.max_pos, m_tdata[OFS_MAX_POS +: POS_W]);
                    check_field("spread_mv", want.spread_mv,
                                $signed(m_tdata[OFS_SPREAD +: SPREAD_W]));
                    check_field("mean_mv", want.mean_mv, $signed(m_tdata[OFS_MEAN +: MEAN_W]));
                    check_field("used_cells", want.used_cells, m_tdata[OFS_USED +: POS_W]);
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("cell_voltage_statistics_tb failed");
            $finish;
        end
    end

    task automatic add_cell(input int mv, input bit last);
        cell_item_t c;
        c.mv = CELL_W'(mv);
        c.last = last;
        pending_cells.push_back(c);
        total_cells++;
    endtask

    function automatic int pick_cell_mv(input int mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (mode == 1)
            return 65535;
        if (mode == 2)
            return -65536;
        if (r < 45)
            return $urandom_range(2500, 4250);
        if (r < 70)
            return $signed(CELL_W'($urandom));
        if (r < 77)
            return 0;
        if (r < 86)
            return -int'($urandom_range(1, 4000));
        if (r < 93)
            return 65535;
        return -65536;
    endfunction

    initial begin
        int len;
        int mode;
        int unsigned r;
        clear_frame_stats();

        // single-cell frames at the field extremes and zero
        add_cell(65535, 1'b1);
        add_cell(-65536, 1'b1);
        add_cell(0, 1'b1);
        add_cell(1, 1'b1);
        // ties: first minimum and first maximum keep their positions
        add_cell(1, 1'b0);
        add_cell(1, 1'b0);
        add_cell(-5, 1'b0);
        add_cell(65535, 1'b0);
        add_cell(65535, 1'b0);
        add_cell(1, 1'b1);
        // no positive cell: min stays at sentinel, mean over the zero and negative cells
        add_cell(-3, 1'b0);
        add_cell(0, 1'b0);
        add_cell(-4, 1'b0);
        add_cell(-65536, 1'b1);
        // truncation toward zero on a negative mean
        add_cell(-7, 1'b0);
        add_cell(2, 1'b1);

        while (total_cells < 16 + RANDOM_CELLS) begin
            r = $urandom_range(0, 99);
            if (r < 80)
                len = $urandom_range(1, MAX_CELLS);
            else if (r < 92)
                len = $urandom_range(MAX_CELLS + 1, MAX_CELLS + 6);   // over-long frame
            else
                len = MAX_CELLS;
            r = $urandom_range(0, 99);
            mode = (r < 5) ? 1 : (r < 10) ? 2 : 0;   // all-max or all-min frames
            for (int i = 0; i < len; i++)
                add_cell(pick_cell_mv(mode), i == len - 1);
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        wait (cells_sent == total_cells && expected_frames.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("cell_voltage_statistics_tb passed");
        else
            $display("cell_voltage_statistics_tb failed");
        $finish;
    end

endmodule
